[src/dlts_pkg.sv]
// dlts_pkg: shared types, codes and sizes for the delta-list task scheduler
// no dependencies; imported by every module of the block
`default_nettype none
package dlts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W = $clog2(TASK_SLOTS);

  typedef logic [IDX_W-1:0] idx_t;
  localparam idx_t LAST_IDX = idx_t'(TASK_SLOTS - 1);

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_DISP = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  handle;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [31:0] task_id;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic        fired;
    logic [7:0]  fired_handle;
    logic [31:0] fired_id;
  } rsp_word_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic        ready;
    logic [31:0] ident;
  } entry_t;

  typedef enum logic [2:0] {
    SEL_HOLD  = 3'd0,
    SEL_PREV  = 3'd1,
    SEL_NEXT  = 3'd2,
    SEL_EXT   = 3'd3,
    SEL_CLEAR = 3'd4
  } sel_t;

  typedef struct packed {
    sel_t   sel;
    entry_t ext;
  } cell_ctl_t;

endpackage
`default_nettype wire

[src/dlts_cell.sv]
// dlts_cell: one table slot; holds, takes a neighbor, loads or clears
// depends on dlts_pkg
`default_nettype none
module dlts_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dlts_pkg::cell_ctl_t ctl,
  input  wire dlts_pkg::entry_t   prev_entry,
  input  wire dlts_pkg::entry_t   after_entry,
  output dlts_pkg::entry_t        entry
);
  import dlts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      case (ctl.sel)
        SEL_HOLD:  entry <= entry;
        SEL_PREV:  entry <= prev_entry;
        SEL_NEXT:  entry <= after_entry;
        SEL_EXT:   entry <= ctl.ext;
        SEL_CLEAR: entry <= '0;
        default:   entry <= entry;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/dlts_ctrl.sv]
// dlts_ctrl: command sequencer, walks the slot chain one slot per cycle
// depends on dlts_pkg
`default_nettype none
module dlts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire dlts_pkg::cmd_word_t cmd,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output dlts_pkg::rsp_word_t    rsp,
  input  wire dlts_pkg::entry_t  slots [dlts_pkg::TASK_SLOTS],
  output dlts_pkg::cell_ctl_t    ctl [dlts_pkg::TASK_SLOTS]
);
  import dlts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_DEL  = 4'b0100,
    S_FOLD = 4'b1000
  } state_t;

  state_t      state, state_next;
  idx_t        idx, idx_next;
  logic [31:0] sum, sum_next;
  logic [7:0]  h, h_next;
  logic [31:0] d, d_next;
  logic [31:0] p, p_next;
  logic [31:0] tid, tid_next;
  logic [31:0] cmd_id, cmd_id_next;
  logic [31:0] id_counter, id_counter_next;
  logic [31:0] fold_delay, fold_delay_next;
  logic        readd, readd_next;
  logic        fired, fired_next;
  logic [7:0]  fh, fh_next;
  logic [31:0] fid, fid_next;
  logic        rsp_valid_next;
  rsp_word_t   rsp_next;

  entry_t      cur, head, tick_entry, new_entry, moved_entry, folded_entry;
  logic [31:0] sum2, ins, nid, nid_fix, head_dec;
  logic        accept, finish;
  logic [1:0]  fin_status;
  logic [31:0] fin_given;

  assign cmd_ready = (state == S_IDLE) && !rsp_valid;
  assign accept    = cmd_valid && cmd_ready;
  assign cur       = slots[idx];
  assign head      = slots[0];
  assign sum2      = sum + cur.delay;
  assign ins       = d - sum;
  assign nid       = id_counter + 32'd1;
  assign nid_fix   = (nid == 32'd0) ? 32'd1 : nid;

  always_comb begin
    head_dec   = (head.delay != 32'd0) ? head.delay - 32'd1 : 32'd0;
    tick_entry = head;
    tick_entry.delay = head_dec;
    tick_entry.ready = (head_dec == 32'd0);

    new_entry.handle = h;
    new_entry.delay  = ins;
    new_entry.period = p;
    new_entry.ready  = (ins == 32'd0);
    new_entry.ident  = cmd_id;

    moved_entry = cur;
    moved_entry.delay = sum2 - d;

    folded_entry = cur;
    folded_entry.delay = cur.delay + fold_delay;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    sum_next        = sum;
    h_next          = h;
    d_next          = d;
    p_next          = p;
    tid_next        = tid;
    cmd_id_next     = cmd_id;
    id_counter_next = id_counter;
    fold_delay_next = fold_delay;
    readd_next      = readd;
    fired_next      = fired;
    fh_next         = fh;
    fid_next        = fid;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    rsp_next        = rsp;
    finish          = 1'b0;
    fin_status      = ST_DONE;
    fin_given       = 32'd0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      ctl[j] = '{sel: SEL_HOLD, ext: '0};
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          fired_next = 1'b0;
          fh_next    = 8'd0;
          fid_next   = 32'd0;
          case (cmd.mode)
            MODE_TICK: begin
              if (head.handle != 8'd0 && !head.ready) begin
                ctl[0] = '{sel: SEL_EXT, ext: tick_entry};
              end
              finish = 1'b1;
            end
            MODE_ADD: begin
              if (cmd.handle == 8'd0) begin
                finish     = 1'b1;
                fin_status = ST_REJECT;
              end else begin
                h_next          = cmd.handle;
                d_next          = cmd.first_delay;
                p_next          = cmd.repeat_period;
                id_counter_next = nid_fix;
                cmd_id_next     = nid_fix;
                idx_next        = '0;
                sum_next        = 32'd0;
                state_next      = S_ADD;
              end
            end
            MODE_DEL: begin
              if (cmd.task_id == 32'd0) begin
                finish     = 1'b1;
                fin_status = ST_REJECT;
              end else begin
                tid_next   = cmd.task_id;
                idx_next   = '0;
                state_next = S_DEL;
              end
            end
            default: begin
              if (head.ready && head.handle != 8'd0) begin
                fired_next      = 1'b1;
                fh_next         = head.handle;
                fid_next        = head.ident;
                h_next          = head.handle;
                d_next          = head.period;
                p_next          = head.period;
                readd_next      = (head.period != 32'd0);
                fold_delay_next = head.delay;
                idx_next        = '0;
                for (int j = 0; j < TASK_SLOTS; j++) begin
                  ctl[j].sel = SEL_NEXT;
                end
                state_next = S_FOLD;
              end else begin
                finish     = 1'b1;
                fin_status = ST_IDLE;
              end
            end
          endcase
        end
      end

      S_DEL: begin
        if (cur.ident == tid) begin
          // close the gap, delay folded into the new occupant next cycle
          for (int j = 0; j < TASK_SLOTS; j++) begin
            if (j >= int'(idx)) begin
              ctl[j].sel = SEL_NEXT;
            end
          end
          fold_delay_next = cur.delay;
          readd_next      = 1'b0;
          state_next      = S_FOLD;
        end else if (idx == LAST_IDX) begin
          finish     = 1'b1;
          fin_status = ST_REJECT;
        end else begin
          idx_next = idx + idx_t'(1);
        end
      end

      S_FOLD: begin
        if (cur.handle != 8'd0) begin
          for (int j = 0; j < TASK_SLOTS; j++) begin
            if (j == int'(idx)) begin
              ctl[j] = '{sel: SEL_EXT, ext: folded_entry};
            end
          end
        end
        if (readd) begin
          id_counter_next = nid_fix;
          cmd_id_next     = nid_fix;
          idx_next        = '0;
          sum_next        = 32'd0;
          readd_next      = 1'b0;
          state_next      = S_ADD;
        end else begin
          finish = 1'b1;
        end
      end

      S_ADD: begin
        if (cur.handle == 8'd0) begin
          for (int j = 0; j < TASK_SLOTS; j++) begin
            if (j == int'(idx)) begin
              ctl[j] = '{sel: SEL_EXT, ext: new_entry};
            end
          end
          finish    = 1'b1;
          fin_given = cmd_id;
        end else if (d < sum2) begin
          for (int j = 0; j < TASK_SLOTS; j++) begin
            if (j == int'(idx)) begin
              ctl[j] = '{sel: SEL_EXT, ext: new_entry};
            end else if (j == int'(idx) + 1) begin
              ctl[j] = '{sel: SEL_EXT, ext: moved_entry};
            end else if (j > int'(idx)) begin
              ctl[j].sel = SEL_PREV;
            end
          end
          finish     = 1'b1;
          fin_given  = cmd_id;
          fin_status = (slots[LAST_IDX].handle != 8'd0) ? ST_DROPPED : ST_DONE;
        end else if (idx == LAST_IDX) begin
          finish     = 1'b1;
          fin_status = ST_DROPPED;
        end else begin
          idx_next = idx + idx_t'(1);
          sum_next = sum2;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next           = S_IDLE;
      rsp_valid_next       = 1'b1;
      rsp_next.status      = fin_status;
      rsp_next.assigned_id = fin_given;
      rsp_next.fired       = fired_next;
      rsp_next.fired_handle = fh_next;
      rsp_next.fired_id    = fid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      id_counter <= 32'd0;
      readd      <= 1'b0;
    end else begin
      state      <= state_next;
      rsp_valid  <= rsp_valid_next;
      id_counter <= id_counter_next;
      readd      <= readd_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    sum        <= sum_next;
    h          <= h_next;
    d          <= d_next;
    p          <= p_next;
    tid        <= tid_next;
    cmd_id     <= cmd_id_next;
    fold_delay <= fold_delay_next;
    fired      <= fired_next;
    fh         <= fh_next;
    fid        <= fid_next;
    rsp        <= rsp_next;
  end

endmodule
`default_nettype wire

[src/delta_list_task_scheduler_unit.sv]
// delta_list_task_scheduler_unit: top level, chain of slot cells plus sequencer
// depends on dlts_pkg, dlts_cell, dlts_ctrl
// sequence: tick completes on acceptance; add walks the slots from the head;
//   delete walks the slots, then folds; dispatch shifts and folds, plus an add walk
//   when the task is periodic; the walk visits one slot per cycle
// throughput: one word at a time, next word taken after the result is taken
// reset: synchronous, clears every slot, the id counter and the handshakes
`default_nettype none
module delta_list_task_scheduler_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire dlts_pkg::cmd_word_t cmd,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output dlts_pkg::rsp_word_t  rsp
);
  import dlts_pkg::*;

  // slot contents, slot 0 is the head of the delta list
  entry_t    slots [TASK_SLOTS];
  // per-slot select and load value from the sequencer
  cell_ctl_t ctl [TASK_SLOTS];

  dlts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .slots     (slots),
    .ctl       (ctl)
  );

  // each cell sees its neighbors: prev toward the head, after toward the tail
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    entry_t prev_e, after_e;
    if (g == 0) begin : g_head
      assign prev_e = '0;
    end else begin : g_mid_prev
      assign prev_e = slots[g-1];
    end
    if (g == TASK_SLOTS - 1) begin : g_tail
      // shifting toward the head empties the tail slot
      assign after_e = '0;
    end else begin : g_mid_after
      assign after_e = slots[g+1];
    end
    dlts_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[g]),
      .prev_entry  (prev_e),
      .after_entry (after_e),
      .entry       (slots[g])
    );
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for delta_list_task_scheduler_unit
// depends on dlts_pkg; predicts every response word and compares field by field
`default_nettype none
module tb_top;
  import dlts_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_word_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_word_t rsp;

  delta_list_task_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the task table
  logic [7:0]  sh_handle [TASK_SLOTS];
  logic [31:0] sh_delay  [TASK_SLOTS];
  logic [31:0] sh_period [TASK_SLOTS];
  logic        sh_ready  [TASK_SLOTS];
  logic [31:0] sh_ident  [TASK_SLOTS];
  logic [31:0] sh_next_id;

  rsp_word_t pending_rsp[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic void shadow_clear();
    for (int i = 0; i < TASK_SLOTS; i++) begin
      sh_handle[i] = '0; sh_delay[i] = '0; sh_period[i] = '0;
      sh_ready[i] = 1'b0; sh_ident[i] = '0;
    end
    sh_next_id = '0;
  endfunction

  function automatic void shadow_move(int dst, int src);
    sh_handle[dst] = sh_handle[src]; sh_delay[dst] = sh_delay[src];
    sh_period[dst] = sh_period[src]; sh_ready[dst] = sh_ready[src];
    sh_ident[dst] = sh_ident[src];
  endfunction

  function automatic void shadow_fill(int k, logic [7:0] h, logic [31:0] d,
                                      logic [31:0] p, logic [31:0] id);
    sh_handle[k] = h; sh_delay[k] = d; sh_period[k] = p;
    sh_ready[k] = (d == 0); sh_ident[k] = id;
  endfunction

  // insert into the delta list; returns status, placed id through given
  function automatic logic [1:0] shadow_insert(logic [7:0] h, logic [31:0] d,
                                               logic [31:0] p, output logic [31:0] given);
    logic [31:0] sum;
    logic [31:0] here;
    logic [31:0] id;
    logic lost;
    sum = '0;
    sh_next_id = sh_next_id + 1;
    if (sh_next_id == 0) sh_next_id = 1;
    id = sh_next_id;
    given = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (sh_handle[i] == 0) begin
        shadow_fill(i, h, d - sum, p, id);
        given = id;
        return ST_DONE;
      end
      here = sh_delay[i];
      sum = sum + here;
      if (d < sum) begin
        lost = sh_handle[TASK_SLOTS-1] != 0;
        sh_delay[i] = sum - d;
        for (int j = TASK_SLOTS - 1; j > i; j--) shadow_move(j, j - 1);
        shadow_fill(i, h, d - (sum - here), p, id);
        given = id;
        return lost ? ST_DROPPED : ST_DONE;
      end
    end
    return ST_DROPPED;
  endfunction

  function automatic bit shadow_remove(logic [31:0] id);
    if (id == 0) return 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (sh_ident[i] == id) begin
        if (i < TASK_SLOTS - 1 && sh_handle[i+1] != 0)
          sh_delay[i+1] = sh_delay[i+1] + sh_delay[i];
        for (int j = i; j < TASK_SLOTS - 1; j++) shadow_move(j, j + 1);
        shadow_fill(TASK_SLOTS - 1, '0, '0, '0, '0);
        sh_ready[TASK_SLOTS-1] = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_word_t predict_rsp(cmd_word_t c);
    rsp_word_t r;
    logic [31:0] given;
    logic [7:0] th;
    logic [31:0] tp;
    bit found;
    r = '0;
    given = '0;
    case (c.mode)
      MODE_TICK: begin
        if (sh_handle[0] != 0 && !sh_ready[0]) begin
          if (sh_delay[0] > 0) sh_delay[0] = sh_delay[0] - 1;
          if (sh_delay[0] == 0) sh_ready[0] = 1'b1;
        end
      end
      MODE_ADD: begin
        if (c.handle == 0) r.status = ST_REJECT;
        else r.status = shadow_insert(c.handle, c.first_delay, c.repeat_period, given);
      end
      MODE_DEL: begin
        found = shadow_remove(c.task_id);
        r.status = found ? ST_DONE : ST_REJECT;
      end
      default: begin
        if (sh_ready[0] && sh_handle[0] != 0) begin
          th = sh_handle[0];
          tp = sh_period[0];
          r.fired = 1'b1;
          r.fired_handle = th;
          r.fired_id = sh_ident[0];
          sh_ready[0] = 1'b0;
          found = shadow_remove(r.fired_id);
          if (tp > 0) r.status = shadow_insert(th, tp, tp, given);
        end else begin
          r.status = ST_IDLE;
        end
      end
    endcase
    r.assigned_id = given;
    return r;
  endfunction

  // ids live in the table right now, for targeted deletes
  function automatic logic [31:0] pick_live_id();
    int n;
    n = 0;
    for (int i = 0; i < TASK_SLOTS; i++) if (sh_handle[i] != 0) n++;
    if (n == 0) return sh_next_id;
    return sh_ident[$urandom_range(n - 1, 0)];
  endfunction

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(5, 0))
      0: return 32'd0;
      1: return $urandom_range(3, 0);
      2: return $urandom_range(20, 1);
      3: return 32'hFFFF_FFFF - $urandom_range(3, 0);
      4: return $urandom;
      default: return $urandom_range(8, 0);
    endcase
  endfunction

  // send one command word; prediction happens at acceptance
  // valid stays high into the next word unless the sender idles
  task automatic send_word(cmd_word_t c);
    bit idle;
    idle = ($urandom_range(99, 0) < send_idle_pct);
    if (idle) cmd_valid <= 1'b0;
    while (idle) begin
      @(negedge clk);
      idle = ($urandom_range(99, 0) < send_idle_pct);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_rsp.push_back(predict_rsp(c));
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] m, logic [7:0] h, logic [31:0] d,
                             logic [31:0] p, logic [31:0] id);
    cmd_word_t c;
    c.mode = m; c.handle = h; c.first_delay = d; c.repeat_period = p; c.task_id = id;
    send_word(c);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // receiver side: random ready, compare each accepted word
  always @(negedge clk) begin
    if (!rst) rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    rsp_word_t want;
    cycles <= cycles + 1;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response word %h", rsp);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status); errors++;
        end
        if (rsp.assigned_id !== want.assigned_id) begin
          $error("assigned_id expected %0d actual %0d", want.assigned_id, rsp.assigned_id);
          errors++;
        end
        if (rsp.fired !== want.fired) begin
          $error("fired expected %0d actual %0d", want.fired, rsp.fired); errors++;
        end
        if (rsp.fired_handle !== want.fired_handle) begin
          $error("fired_handle expected %0d actual %0d", want.fired_handle, rsp.fired_handle);
          errors++;
        end
        if (rsp.fired_id !== want.fired_id) begin
          $error("fired_id expected %0d actual %0d", want.fired_id, rsp.fired_id); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // directed: rejects, extremes, fold on delete, ready via tick, one-shot and periodic
  task automatic test_directed();
    send_fields(MODE_DISP, 8'd0, '0, '0, '0);          // nothing due
    send_fields(MODE_ADD, 8'd0, 32'd5, 32'd1, '0);     // handle zero rejected
    send_fields(MODE_DEL, 8'd0, '0, '0, 32'd0);        // id zero rejected
    send_fields(MODE_DEL, 8'd0, '0, '0, 32'hFFFF_FFFF);
    send_fields(MODE_TICK, 8'hFF, '1, '1, '1);         // tick on empty table
    send_fields(MODE_ADD, 8'hFF, 32'd0, 32'd0, '1);    // ready at once, one-shot
    send_fields(MODE_ADD, 8'h01, 32'd3, 32'd2, '0);
    send_fields(MODE_ADD, 8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_fields(MODE_ADD, 8'h5A, 32'd3, 32'd0, '0);    // zero delta behind the handle 01 entry
    send_fields(MODE_DISP, 8'd0, '0, '0, '0);          // one-shot released
    send_fields(MODE_TICK, 8'd0, '0, '0, '0);
    send_fields(MODE_DEL, 8'd0, '0, '0, 32'd2);        // fold delay into next
    send_fields(MODE_TICK, 8'd0, '0, '0, '0);
    send_fields(MODE_TICK, 8'd0, '0, '0, '0);
    send_fields(MODE_TICK, 8'd0, '0, '0, '0);
    send_fields(MODE_TICK, 8'd0, '0, '0, '0);          // ready head left alone
    send_fields(MODE_DISP, 8'd0, '0, '0, '0);
    wait_drained();
  endtask

  // fill past capacity: tail loss and new-entry drop, then periodic re-adds
  task automatic test_full_table();
    for (int i = 0; i < TASK_SLOTS + 2; i++)
      send_fields(MODE_ADD, 8'(i + 1), 32'(10 + i), 32'(i % 3), '0);
    send_fields(MODE_ADD, 8'h77, 32'd1, 32'd4, '0);    // sorts first, tail lost
    send_fields(MODE_ADD, 8'h78, '1, 32'd0, '0);       // sorts last, dropped
    for (int i = 0; i < 40; i++)
      send_fields($urandom_range(1, 0) ? MODE_TICK : MODE_DISP, 8'd0, '0, '0, '0);
    wait_drained();
    for (int i = 0; i < TASK_SLOTS + 2; i++)
      send_fields(MODE_DEL, 8'd0, '0, '0, pick_live_id());
    wait_drained();
  endtask

  task automatic test_random(int count);
    cmd_word_t c;
    for (int n = 0; n < count; n++) begin
      c.mode = 2'($urandom_range(3, 0));
      c.handle = ($urandom_range(15, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
      c.first_delay = rand_delay();
      c.repeat_period = ($urandom_range(2, 0) == 0) ? 32'd0 : rand_delay();
      c.task_id = ($urandom_range(3, 0) == 0) ? $urandom : pick_live_id();
      send_word(c);
      if (n == count / 2) wait_drained();                // sender holds off once
    end
    wait_drained();
  endtask

  initial begin
    shadow_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 19; recv_idle_pct = 59;
    test_directed();
    test_full_table();
    test_random(170);
    send_idle_pct = 59; recv_idle_pct = 19;
    test_random(170);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(170);
    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
